// ===== design/xmlrpc_element_nesting_checker_core_assert.svh =====
// ---------------------------------------------------------------------------
// XML-RPC nesting checker assertion macros
// Shared concurrent assertion forms for the nesting checker.
// ---------------------------------------------------------------------------
`ifndef XMLRPC_ELEMENT_NESTING_CHECKER_CORE_ASSERT_SVH
`define XMLRPC_ELEMENT_NESTING_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/xnc_pkg.sv =====
// ---------------------------------------------------------------------------
// XML-RPC nesting checker package
// Types, codes, widths and grammar functions shared by the checker files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package xnc_pkg;

    localparam int CMD_W  = 2;
    localparam int KIND_W = 5;
    localparam int LEN_W  = 12;
    localparam int CODE_W = 4;

    localparam int             STACK_DEPTH_DEFAULT = 16;
    localparam logic [LEN_W-1:0] MAX_NAME_LEN_RESET = 12'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_CHARS = 2'd2,
        CMD_START = 2'd3
    } t_cmd;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE         = 4'd0,
        EV_START_STRUCT = 4'd1,
        EV_END_STRUCT   = 4'd2,
        EV_START_ARRAY  = 4'd3,
        EV_END_ARRAY    = 4'd4,
        EV_START_MEMBER = 4'd5,
        EV_END_MEMBER   = 4'd6,
        EV_DATA         = 4'd7,
        EV_CHARS        = 4'd8
    } t_event;

    typedef enum logic [CODE_W-1:0] {
        VT_NONE     = 4'd0,
        VT_STRUCT   = 4'd1,
        VT_ARRAY    = 4'd2,
        VT_BASE64   = 4'd3,
        VT_BOOLEAN  = 4'd4,
        VT_DATETIME = 4'd5,
        VT_DOUBLE   = 4'd6,
        VT_INT      = 4'd7,
        VT_STRING   = 4'd8
    } t_vtype;

    typedef enum logic [CODE_W-1:0] {
        ERR_OK            = 4'd0,
        ERR_BAD_CHILD     = 4'd1,
        ERR_STRAY_CHARS   = 4'd2,
        ERR_LONG_NAME     = 4'd3,
        ERR_EMPTY_NAME    = 4'd4,
        ERR_NAMELESS      = 4'd5,
        ERR_TOO_DEEP      = 4'd6,
        ERR_UNMATCHED     = 4'd7,
        ERR_FAULTED       = 4'd8
    } t_err;

    localparam logic [KIND_W-1:0] K_METHODRESPONSE = 5'd0;
    localparam logic [KIND_W-1:0] K_PARAMS         = 5'd1;
    localparam logic [KIND_W-1:0] K_PARAM          = 5'd2;
    localparam logic [KIND_W-1:0] K_VALUE          = 5'd3;
    localparam logic [KIND_W-1:0] K_STRUCT         = 5'd4;
    localparam logic [KIND_W-1:0] K_MEMBER         = 5'd5;
    localparam logic [KIND_W-1:0] K_NAME           = 5'd6;
    localparam logic [KIND_W-1:0] K_ARRAY          = 5'd7;
    localparam logic [KIND_W-1:0] K_DATA           = 5'd8;
    localparam logic [KIND_W-1:0] K_BASE64         = 5'd9;
    localparam logic [KIND_W-1:0] K_BOOLEAN        = 5'd10;
    localparam logic [KIND_W-1:0] K_DATETIME       = 5'd11;
    localparam logic [KIND_W-1:0] K_DOUBLE         = 5'd12;
    localparam logic [KIND_W-1:0] K_INT            = 5'd13;
    localparam logic [KIND_W-1:0] K_I4             = 5'd14;
    localparam logic [KIND_W-1:0] K_STRING         = 5'd15;

    // Operation on the element stack for one accepted beat.
    typedef struct packed {
        logic                push;
        logic                pop;
        logic [KIND_W-1:0]   new_kind;
        logic [CODE_W-1:0]   new_vt;
        logic                top_vt_wr;
        logic [CODE_W-1:0]   top_vt;
        logic                top_flag_set;
        logic                below_flag_set;
        logic                below_vt_wr;
        logic [CODE_W-1:0]   below_vt;
    } t_stack_op;

    // The two innermost open levels.
    typedef struct packed {
        logic [KIND_W-1:0] top_kind;
        logic              top_flag;
        logic [CODE_W-1:0] top_vt;
        logic [KIND_W-1:0] below_kind;
    } t_stack_view;

    function automatic logic is_scalar(input logic [KIND_W-1:0] k);
        return (k >= K_BASE64) && (k <= K_STRING);
    endfunction

    function automatic logic [CODE_W-1:0] own_type(input logic [KIND_W-1:0] k);
        logic [CODE_W-1:0] t;
        unique case (k) inside
            K_STRUCT:      t = VT_STRUCT;
            K_ARRAY:       t = VT_ARRAY;
            K_BASE64:      t = VT_BASE64;
            K_BOOLEAN:     t = VT_BOOLEAN;
            K_DATETIME:    t = VT_DATETIME;
            K_DOUBLE:      t = VT_DOUBLE;
            K_INT, K_I4:   t = VT_INT;
            K_STRING:      t = VT_STRING;
            default:       t = VT_NONE;
        endcase
        return t;
    endfunction

    function automatic logic parent_ok(input logic [KIND_W-1:0] k,
                                       input logic              has_parent,
                                       input logic [KIND_W-1:0] p);
        logic ok;
        unique case (k) inside
            K_METHODRESPONSE: ok = !has_parent;
            K_PARAMS:         ok = has_parent && (p == K_METHODRESPONSE);
            K_PARAM:          ok = has_parent && (p == K_PARAMS);
            K_VALUE:          ok = has_parent && ((p == K_PARAM) || (p == K_MEMBER)
                                                  || (p == K_DATA));
            K_MEMBER:         ok = has_parent && (p == K_STRUCT);
            K_NAME:           ok = has_parent && (p == K_MEMBER);
            K_DATA:           ok = has_parent && (p == K_ARRAY);
            K_STRUCT, K_ARRAY, [K_BASE64:K_STRING]:
                              ok = has_parent && (p == K_VALUE);
            default:          ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ===== design/xnc_in_if.sv =====
// ---------------------------------------------------------------------------
// XML-RPC nesting checker input channel
// Valid/ready channel carrying one tag-level event per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface xnc_in_if;
    logic                       valid;
    logic                       ready;
    logic [xnc_pkg::CMD_W-1:0]  command;
    logic [xnc_pkg::KIND_W-1:0] element_kind;
    logic [xnc_pkg::LEN_W-1:0]  text_length;

    modport source (output valid, output command, output element_kind,
                    output text_length, input ready);
    modport sink   (input valid, input command, input element_kind,
                    input text_length, output ready);
endinterface

// ===== design/xnc_out_if.sv =====
// ---------------------------------------------------------------------------
// XML-RPC nesting checker output channel
// Valid/ready channel carrying one decoder event or error per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface xnc_out_if;
    logic                       valid;
    logic                       ready;
    logic [xnc_pkg::CODE_W-1:0] event_code;
    logic [xnc_pkg::CODE_W-1:0] value_type;
    logic [xnc_pkg::CODE_W-1:0] error_code;
    logic [xnc_pkg::LEN_W-1:0]  event_length;

    modport source (output valid, output event_code, output value_type,
                    output error_code, output event_length, input ready);
    modport sink   (input valid, input event_code, input value_type,
                    input error_code, input event_length, output ready);
endinterface

// ===== design/xnc_stack.sv =====
// ---------------------------------------------------------------------------
// XML-RPC nesting checker element stack
// Shift-register stack of open levels; the top sits at entry 0.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module xnc_stack #(
    parameter int DEPTH = xnc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                 i_clk,
    input  xnc_pkg::t_stack_op   i_op,
    output xnc_pkg::t_stack_view o_view
);

    logic [xnc_pkg::KIND_W-1:0] r_kind [DEPTH];
    logic                       r_flag [DEPTH];
    logic [xnc_pkg::CODE_W-1:0] r_vt   [DEPTH];

    logic [xnc_pkg::KIND_W-1:0] m_kind [DEPTH];
    logic                       m_flag [DEPTH];
    logic [xnc_pkg::CODE_W-1:0] m_vt   [DEPTH];

    // Level edits are applied to the current layout first, then the shift.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            m_kind[i] = r_kind[i];
            m_flag[i] = r_flag[i];
            m_vt[i]   = r_vt[i];
        end
        if (i_op.top_vt_wr) begin
            m_vt[0] = i_op.top_vt;
        end
        if (i_op.top_flag_set) begin
            m_flag[0] = 1'b1;
        end
        if (i_op.below_flag_set) begin
            m_flag[1] = 1'b1;
        end
        if (i_op.below_vt_wr) begin
            m_vt[1] = i_op.below_vt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_op.push) begin
                if (i == 0) begin
                    r_kind[i] <= i_op.new_kind;
                    r_flag[i] <= 1'b0;
                    r_vt[i]   <= i_op.new_vt;
                end else begin
                    r_kind[i] <= m_kind[i-1];
                    r_flag[i] <= m_flag[i-1];
                    r_vt[i]   <= m_vt[i-1];
                end
            end else if (i_op.pop && (i < DEPTH - 1)) begin
                r_kind[i] <= m_kind[i+1];
                r_flag[i] <= m_flag[i+1];
                r_vt[i]   <= m_vt[i+1];
            end else begin
                r_kind[i] <= m_kind[i];
                r_flag[i] <= m_flag[i];
                r_vt[i]   <= m_vt[i];
            end
        end
    end

    assign o_view.top_kind   = r_kind[0];
    assign o_view.top_flag   = r_flag[0];
    assign o_view.top_vt     = r_vt[0];
    assign o_view.below_kind = r_kind[1];

endmodule

// ===== design/xmlrpc_element_nesting_checker_core.sv =====
// ---------------------------------------------------------------------------
// XML-RPC element nesting checker
// Checks the parent/child grammar of XML-RPC response tag events and turns
// each event into one decoder event or error code. Every input beat yields
// exactly one output beat. An item is taken in every cycle while the output
// register is empty or being drained, so the sustained rate is one item per
// clock, and each result is registered and shows in the cycle after its
// input is accepted. The rate rests on the update of the two innermost
// stack levels, which sit at fixed places of a shift-register stack. After
// an error, every event but start document answers faulted until a start
// document arrives.
`timescale 1ns / 1ps

module xmlrpc_element_nesting_checker_core #(
    parameter int STACK_DEPTH = xnc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [xnc_pkg::LEN_W-1:0] i_cfg_wr_data,
    xnc_in_if.sink                    i_in,
    xnc_out_if.source                 o_out
);

    `include "xmlrpc_element_nesting_checker_core_assert.svh"

    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0]                r_depth;
    logic                         r_fault;
    logic [xnc_pkg::LEN_W-1:0]    r_pend_len;
    logic [xnc_pkg::LEN_W-1:0]    r_max_len;

    logic                         r_out_valid;
    logic [xnc_pkg::CODE_W-1:0]   r_ev;
    logic [xnc_pkg::CODE_W-1:0]   r_vt;
    logic [xnc_pkg::CODE_W-1:0]   r_err;
    logic [xnc_pkg::LEN_W-1:0]    r_len;

    logic [xnc_pkg::CODE_W-1:0]   n_ev;
    logic [xnc_pkg::CODE_W-1:0]   n_vt;
    logic [xnc_pkg::CODE_W-1:0]   n_err;
    logic [xnc_pkg::LEN_W-1:0]    n_len;

    xnc_pkg::t_stack_op           s_req;
    xnc_pkg::t_stack_op           s_op;
    xnc_pkg::t_stack_view         s_view;

    xnc_pkg::t_cmd                s_cmd;
    logic                         s_accept;
    logic                         s_has_top;
    logic                         s_has_below;
    logic                         s_full;
    logic [xnc_pkg::CODE_W-1:0]   s_own;
    logic                         s_pend_clr;
    logic                         s_pend_wr;
    logic                         s_ok;

    assign s_cmd       = xnc_pkg::t_cmd'(i_in.command);
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign s_accept    = i_in.valid && i_in.ready;
    assign s_has_top   = (r_depth != '0);
    assign s_has_below = (r_depth > DW'(1));
    assign s_full      = (r_depth == DW'(STACK_DEPTH));
    assign s_own       = xnc_pkg::own_type(i_in.element_kind);

    always_comb begin
        n_ev       = xnc_pkg::EV_NONE;
        n_vt       = xnc_pkg::VT_NONE;
        n_err      = xnc_pkg::ERR_OK;
        n_len      = '0;
        s_req      = '0;
        s_pend_clr = 1'b0;
        s_pend_wr  = 1'b0;
        s_req.new_kind = i_in.element_kind;
        s_req.new_vt   = s_own;
        s_req.top_vt   = s_own;
        s_req.below_vt = s_view.top_vt;
        if (s_cmd == xnc_pkg::CMD_START) begin
            s_pend_clr = 1'b1;
        end else if (r_fault) begin
            n_err = xnc_pkg::ERR_FAULTED;
        end else begin
            case (s_cmd)
                xnc_pkg::CMD_OPEN: begin
                    if (s_full) begin
                        n_err = xnc_pkg::ERR_TOO_DEEP;
                    end else if (!xnc_pkg::parent_ok(i_in.element_kind, s_has_top,
                                                     s_view.top_kind)) begin
                        n_err = xnc_pkg::ERR_BAD_CHILD;
                    end else begin
                        s_req.push      = 1'b1;
                        s_req.top_vt_wr = (s_own != xnc_pkg::VT_NONE);
                        s_pend_clr      = (i_in.element_kind == xnc_pkg::K_NAME);
                        if (i_in.element_kind == xnc_pkg::K_STRUCT) begin
                            n_ev = xnc_pkg::EV_START_STRUCT;
                            n_vt = xnc_pkg::VT_STRUCT;
                        end else if (i_in.element_kind == xnc_pkg::K_ARRAY) begin
                            n_ev = xnc_pkg::EV_START_ARRAY;
                            n_vt = xnc_pkg::VT_ARRAY;
                        end else if (i_in.element_kind == xnc_pkg::K_DATA) begin
                            n_ev = xnc_pkg::EV_DATA;
                        end
                    end
                end
                xnc_pkg::CMD_CHARS: begin
                    if (!s_has_top) begin
                        n_err = xnc_pkg::ERR_STRAY_CHARS;
                    end else if (s_view.top_kind == xnc_pkg::K_NAME) begin
                        if (i_in.text_length > r_max_len) begin
                            n_err = xnc_pkg::ERR_LONG_NAME;
                        end else begin
                            s_pend_wr = 1'b1;
                        end
                    end else if (xnc_pkg::is_scalar(s_view.top_kind)) begin
                        s_req.top_flag_set = 1'b1;
                        n_ev  = xnc_pkg::EV_CHARS;
                        n_vt  = s_view.top_vt;
                        n_len = i_in.text_length;
                    end else begin
                        n_err = xnc_pkg::ERR_STRAY_CHARS;
                    end
                end
                default: begin
                    // Close element: closes the top level unless it reports an error.
                    if (!s_has_top) begin
                        n_err = xnc_pkg::ERR_UNMATCHED;
                    end else begin
                        s_req.pop = 1'b1;
                        if (s_view.top_kind == xnc_pkg::K_MEMBER) begin
                            if (!s_view.top_flag) begin
                                n_err = xnc_pkg::ERR_NAMELESS;
                            end else begin
                                n_ev = xnc_pkg::EV_END_MEMBER;
                                n_vt = s_view.top_vt;
                            end
                        end else if (s_view.top_kind == xnc_pkg::K_NAME) begin
                            if (r_pend_len == '0) begin
                                n_err = xnc_pkg::ERR_EMPTY_NAME;
                            end else begin
                                n_ev  = xnc_pkg::EV_START_MEMBER;
                                n_len = r_pend_len;
                                s_req.below_flag_set = s_has_below;
                            end
                        end else if (s_view.top_kind == xnc_pkg::K_STRUCT) begin
                            n_ev = xnc_pkg::EV_END_STRUCT;
                            n_vt = xnc_pkg::VT_STRUCT;
                        end else if (s_view.top_kind == xnc_pkg::K_ARRAY) begin
                            n_ev = xnc_pkg::EV_END_ARRAY;
                            n_vt = xnc_pkg::VT_ARRAY;
                        end else if (xnc_pkg::is_scalar(s_view.top_kind)) begin
                            // A scalar with no text still reports an empty run.
                            if (!s_view.top_flag) begin
                                n_ev = xnc_pkg::EV_CHARS;
                                n_vt = s_view.top_vt;
                            end
                        end else if (s_view.top_kind == xnc_pkg::K_VALUE) begin
                            s_req.below_vt_wr = s_has_below &&
                                (s_view.below_kind == xnc_pkg::K_MEMBER);
                        end
                    end
                end
            endcase
        end
    end

    assign s_ok = (n_err == xnc_pkg::ERR_OK);

    always_comb begin
        s_op                = s_req;
        s_op.push           = s_req.push && s_accept && s_ok;
        s_op.pop            = s_req.pop && s_accept && s_ok;
        s_op.top_vt_wr      = s_req.top_vt_wr && s_accept && s_ok;
        s_op.top_flag_set   = s_req.top_flag_set && s_accept && s_ok;
        s_op.below_flag_set = s_req.below_flag_set && s_accept && s_ok;
        s_op.below_vt_wr    = s_req.below_vt_wr && s_accept && s_ok;
    end

    xnc_stack #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_op   (s_op),
        .o_view (s_view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_fault     <= 1'b0;
            r_pend_len  <= '0;
            r_max_len   <= xnc_pkg::MAX_NAME_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (s_accept) begin
                r_out_valid <= 1'b1;
                if (s_cmd == xnc_pkg::CMD_START) begin
                    r_depth <= '0;
                    r_fault <= 1'b0;
                end else if (!s_ok && (n_err != xnc_pkg::ERR_FAULTED)) begin
                    r_fault <= 1'b1;
                end else if (s_op.push) begin
                    r_depth <= r_depth + DW'(1);
                end else if (s_op.pop) begin
                    r_depth <= r_depth - DW'(1);
                end
                if (s_pend_clr) begin
                    r_pend_len <= '0;
                end else if (s_pend_wr) begin
                    r_pend_len <= i_in.text_length;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ev  <= n_ev;
            r_vt  <= n_vt;
            r_err <= n_err;
            r_len <= n_len;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_code   = r_ev;
    assign o_out.value_type   = r_vt;
    assign o_out.error_code   = r_err;
    assign o_out.event_length = r_len;

    `XNC_ASSERT_NOW(a_err_clears_event, i_clk, i_rst_n,
        r_out_valid && (r_err != xnc_pkg::ERR_OK),
        (r_ev == xnc_pkg::EV_NONE) && (r_vt == xnc_pkg::VT_NONE) && (r_len == '0),
        "error beat carries an event")
    `XNC_ASSERT_NOW(a_depth_bound, i_clk, i_rst_n,
        1'b1, r_depth <= DW'(STACK_DEPTH),
        "stack depth beyond its size")
    `XNC_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n,
        s_accept && (s_cmd == xnc_pkg::CMD_START),
        !r_fault && (r_depth == '0) && (r_pend_len == '0),
        "start document did not clear the state")
    `XNC_ASSERT_NEXT(a_fault_sticky, i_clk, i_rst_n,
        s_accept && r_fault && (s_cmd != xnc_pkg::CMD_START),
        r_fault && (r_err == xnc_pkg::ERR_FAULTED) && $stable(r_depth),
        "faulted checker changed state or answered")

endmodule

// ===== sim/xmlrpc_element_nesting_checker_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// XML-RPC element nesting checker testbench
// Drives tag events through the input channel from a queue, predicts every
// decoder event with a local copy of the element stack and the grammar, and
// compares each output beat field by field. A short directed sequence comes
// first, then random XML-RPC responses, mostly well formed and some broken,
// under several name length limits and idle patterns on both channels.
// ---------------------------------------------------------------------------

module xmlrpc_element_nesting_checker_core_tb;
    import xnc_pkg::*;

    localparam int NEST_LEVELS = STACK_DEPTH_DEFAULT;
    localparam int PHASES      = 5;

    typedef struct packed {
        t_cmd              cmd;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
    } t_tag_event;

    typedef struct packed {
        t_event           ev;
        t_vtype           vt;
        t_err             err;
        logic [LEN_W-1:0] len;
    } t_decoded_beat;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [LEN_W-1:0] i_cfg_wr_data;

    xnc_in_if  tag_if ();
    xnc_out_if dec_if ();

    xmlrpc_element_nesting_checker_core #(
        .STACK_DEPTH (NEST_LEVELS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (tag_if),
        .o_out         (dec_if)
    );

    // Local copy of the checker state.
    logic [KIND_W-1:0] nest_kind [NEST_LEVELS];
    logic              nest_flag [NEST_LEVELS];
    t_vtype            nest_vt   [NEST_LEVELS];
    logic [LEN_W-1:0]  name_len_held;
    logic [LEN_W-1:0]  name_len_limit;
    int                nest_depth;
    logic              doc_faulted;

    t_tag_event    tags_to_send [$];
    t_decoded_beat decoded_expected [$];
    t_tag_event    next_tag;
    int unsigned   tags_queued;
    int unsigned   tags_taken;
    int unsigned   error_count;
    bit            in_fire;
    int            sender_idle_pct;
    int            receiver_stall_pct;

    // Stimulus shaping.
    int gen_depth;
    int noise_permille;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_vtype vtype_of_kind(input logic [KIND_W-1:0] k);
        case (k)
            K_STRUCT:     return VT_STRUCT;
            K_ARRAY:      return VT_ARRAY;
            K_BASE64:     return VT_BASE64;
            K_BOOLEAN:    return VT_BOOLEAN;
            K_DATETIME:   return VT_DATETIME;
            K_DOUBLE:     return VT_DOUBLE;
            K_INT, K_I4:  return VT_INT;
            K_STRING:     return VT_STRING;
            default:      return VT_NONE;
        endcase
    endfunction

    function automatic logic is_leaf(input logic [KIND_W-1:0] k);
        return (k >= K_BASE64) && (k <= K_STRING);
    endfunction

    // Grammar seen from the parent: which children each open element takes.
    function automatic logic child_allowed(input logic [KIND_W-1:0] k,
                                           input logic              has_parent,
                                           input logic [KIND_W-1:0] p);
        if (k == K_METHODRESPONSE) return !has_parent;
        if (!has_parent) return 1'b0;
        case (p)
            K_METHODRESPONSE: return k == K_PARAMS;
            K_PARAMS:         return k == K_PARAM;
            K_PARAM:          return k == K_VALUE;
            K_STRUCT:         return k == K_MEMBER;
            K_MEMBER:         return (k == K_VALUE) || (k == K_NAME);
            K_ARRAY:          return k == K_DATA;
            K_DATA:           return k == K_VALUE;
            K_VALUE:          return (k == K_STRUCT) || (k == K_ARRAY) || is_leaf(k);
            default:          return 1'b0;
        endcase
    endfunction

    function automatic t_decoded_beat decode_tag_event(input t_tag_event te);
        t_decoded_beat     res;
        int                top;
        logic [KIND_W-1:0] top_kind;
        t_vtype            t;
        res      = '{ev: EV_NONE, vt: VT_NONE, err: ERR_OK, len: '0};
        top      = nest_depth - 1;
        top_kind = (nest_depth > 0) ? nest_kind[top] : K_METHODRESPONSE;
        if (te.cmd == CMD_START) begin
            nest_depth    = 0;
            doc_faulted   = 1'b0;
            name_len_held = '0;
        end else if (doc_faulted) begin
            res.err = ERR_FAULTED;
        end else begin
            case (te.cmd)
                CMD_OPEN: begin
                    if (nest_depth >= NEST_LEVELS) begin
                        res.err = ERR_TOO_DEEP;
                    end else if (!child_allowed(te.kind, nest_depth > 0, top_kind)) begin
                        res.err = ERR_BAD_CHILD;
                    end else begin
                        t = vtype_of_kind(te.kind);
                        nest_kind[nest_depth] = te.kind;
                        nest_flag[nest_depth] = 1'b0;
                        nest_vt[nest_depth]   = t;
                        // A typed child also marks the type on its value.
                        if (t != VT_NONE && nest_depth > 0) nest_vt[top] = t;
                        nest_depth++;
                        if (te.kind == K_NAME) name_len_held = '0;
                        case (te.kind)
                            K_STRUCT: begin
                                res.ev = EV_START_STRUCT;
                                res.vt = VT_STRUCT;
                            end
                            K_ARRAY: begin
                                res.ev = EV_START_ARRAY;
                                res.vt = VT_ARRAY;
                            end
                            K_DATA:  res.ev = EV_DATA;
                            default: ;
                        endcase
                    end
                end
                CMD_CHARS: begin
                    if (nest_depth == 0) begin
                        res.err = ERR_STRAY_CHARS;
                    end else if (top_kind == K_NAME) begin
                        if (te.len > name_len_limit) res.err = ERR_LONG_NAME;
                        else name_len_held = te.len;
                    end else if (is_leaf(top_kind)) begin
                        nest_flag[top] = 1'b1;
                        res.ev  = EV_CHARS;
                        res.vt  = nest_vt[top];
                        res.len = te.len;
                    end else begin
                        res.err = ERR_STRAY_CHARS;
                    end
                end
                default: begin
                    if (nest_depth == 0) begin
                        res.err = ERR_UNMATCHED;
                    end else begin
                        if (top_kind == K_MEMBER) begin
                            if (!nest_flag[top]) begin
                                res.err = ERR_NAMELESS;
                            end else begin
                                res.ev = EV_END_MEMBER;
                                res.vt = nest_vt[top];
                            end
                        end else if (top_kind == K_NAME) begin
                            if (name_len_held == '0) begin
                                res.err = ERR_EMPTY_NAME;
                            end else begin
                                res.ev  = EV_START_MEMBER;
                                res.len = name_len_held;
                                if (top > 0) nest_flag[top-1] = 1'b1;
                            end
                        end else if (top_kind == K_STRUCT) begin
                            res.ev = EV_END_STRUCT;
                            res.vt = VT_STRUCT;
                        end else if (top_kind == K_ARRAY) begin
                            res.ev = EV_END_ARRAY;
                            res.vt = VT_ARRAY;
                        end else if (is_leaf(top_kind)) begin
                            // A scalar without text still reports an empty run.
                            if (!nest_flag[top]) begin
                                res.ev = EV_CHARS;
                                res.vt = nest_vt[top];
                            end
                        end else if (top_kind == K_VALUE) begin
                            if (top > 0 && nest_kind[top-1] == K_MEMBER)
                                nest_vt[top-1] = nest_vt[top];
                        end
                        if (res.err == ERR_OK) nest_depth = top;
                    end
                end
            endcase
        end
        if (res.err != ERR_OK) begin
            if (res.err != ERR_FAULTED) doc_faulted = 1'b1;
            res.ev  = EV_NONE;
            res.vt  = VT_NONE;
            res.len = '0;
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endtask

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        t_decoded_beat want;
        in_fire = i_rst_n && tag_if.valid && tag_if.ready;
        if (in_fire) begin
            decoded_expected.push_back(decode_tag_event('{cmd:  t_cmd'(tag_if.command),
                                                          kind: tag_if.element_kind,
                                                          len:  tag_if.text_length}));
            tags_taken++;
        end
        if (i_rst_n && dec_if.valid && dec_if.ready) begin
            if (decoded_expected.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got event %0d error %0d",
                         $time, dec_if.event_code, dec_if.error_code);
                error_count++;
            end else begin
                want = decoded_expected.pop_front();
                check_field("event_code", LEN_W'(want.ev), LEN_W'(dec_if.event_code));
                check_field("value_type", LEN_W'(want.vt), LEN_W'(dec_if.value_type));
                check_field("error_code", LEN_W'(want.err), LEN_W'(dec_if.error_code));
                check_field("event_length", want.len, dec_if.event_length);
            end
        end
    end

    // Drive both channels at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tag_if.valid <= 1'b0;
            dec_if.ready <= 1'b0;
        end else begin
            if (!tag_if.valid || in_fire) begin
                if (tags_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_tag = tags_to_send.pop_front();
                    tag_if.valid        <= 1'b1;
                    tag_if.command      <= next_tag.cmd;
                    tag_if.element_kind <= next_tag.kind;
                    tag_if.text_length  <= next_tag.len;
                end else begin
                    tag_if.valid <= 1'b0;
                end
            end
            dec_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic put(input t_cmd c, input logic [KIND_W-1:0] k,
                       input logic [LEN_W-1:0] l);
        tags_to_send.push_back('{cmd: c, kind: k, len: l});
        tags_queued++;
    endtask

    task automatic put_shaped(input t_cmd c, input logic [KIND_W-1:0] k,
                              input logic [LEN_W-1:0] l);
        if ($urandom_range(999) < noise_permille)
            put(t_cmd'(CMD_W'($urandom_range(3))), KIND_W'($urandom_range(31)),
                LEN_W'($urandom_range(4095)));
        put(c, k, l);
    endtask

    task automatic emit_open(input logic [KIND_W-1:0] k);
        put_shaped(CMD_OPEN, k, LEN_W'($urandom_range(4095)));
        gen_depth++;
    endtask

    task automatic emit_close();
        put_shaped(CMD_CLOSE, KIND_W'($urandom_range(31)), LEN_W'($urandom_range(4095)));
        gen_depth--;
    endtask

    task automatic emit_chars(input logic [LEN_W-1:0] l);
        put_shaped(CMD_CHARS, KIND_W'($urandom_range(31)), l);
    endtask

    function automatic logic [LEN_W-1:0] pick_name_len();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10 && name_len_limit < 4095)
            return LEN_W'($urandom_range(4095, name_len_limit + 1));
        if (r < 15) return name_len_limit;
        return LEN_W'($urandom_range((name_len_limit < 48) ? name_len_limit : 48, 1));
    endfunction

    task automatic gen_member();
        int runs;
        emit_open(K_MEMBER);
        // A few members go without a name.
        if ($urandom_range(99) >= 4) begin
            emit_open(K_NAME);
            runs = ($urandom_range(99) < 8) ? 2 : (($urandom_range(99) < 4) ? 0 : 1);
            repeat (runs) emit_chars(pick_name_len());
            emit_close();
        end
        gen_value(1'b0);
        emit_close();
    endtask

    task automatic gen_value(input bit deep);
        int r;
        int n;
        int compound_pct;
        if (gen_depth >= NEST_LEVELS) begin
            // Already at or past the stack limit: one more open is enough.
            emit_open(KIND_W'($urandom_range(31)));
            emit_close();
            return;
        end
        emit_open(K_VALUE);
        r = $urandom_range(99);
        compound_pct = deep ? 100 : (gen_depth < 7) ? 45 : (gen_depth < 12) ? 20 : 8;
        if (r < compound_pct) begin
            if (deep || $urandom_range(1)) begin
                emit_open(K_ARRAY);
                emit_open(K_DATA);
                n = deep ? 1 : $urandom_range(3);
                repeat (n) gen_value(deep);
                emit_close();
                emit_close();
            end else begin
                emit_open(K_STRUCT);
                n = $urandom_range(3, 1);
                repeat (n) gen_member();
                emit_close();
            end
        end else if (r < 94) begin
            emit_open(KIND_W'($urandom_range(K_STRING, K_BASE64)));
            n = $urandom_range(2);
            repeat (n) emit_chars(LEN_W'(($urandom_range(3) == 0) ? $urandom_range(8)
                                                                   : $urandom_range(4095)));
            emit_close();
        end
        emit_close();
    endtask

    task automatic gen_document();
        bit deep;
        int n;
        noise_permille = ($urandom_range(99) < 75) ? 0 : 30;
        deep = ($urandom_range(99) < 4);
        gen_depth = 0;
        if ($urandom_range(99) >= 8)
            put(CMD_START, KIND_W'($urandom_range(31)), LEN_W'($urandom_range(4095)));
        emit_open(K_METHODRESPONSE);
        emit_open(K_PARAMS);
        n = $urandom_range(2, 1);
        repeat (n) begin
            emit_open(K_PARAM);
            gen_value(deep);
            emit_close();
        end
        emit_close();
        emit_close();
        if ($urandom_range(99) < 3) emit_close();
    endtask

    task automatic wait_drained();
        while (tags_taken != tags_queued || decoded_expected.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_name_limit(input logic [LEN_W-1:0] lim);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = lim;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        name_len_limit = lim;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
            3:       begin sender_idle_pct = 34; receiver_stall_pct = 34; end
            default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        endcase
    endtask

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int          p;
        int unsigned phase_end;
        int          modes [PHASES];
        modes = '{1, 2, 3, 0, 3};
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_wr_en         = 1'b0;
        i_cfg_wr_data       = '0;
        tag_if.valid        = 1'b0;
        tag_if.command      = CMD_START;
        tag_if.element_kind = '0;
        tag_if.text_length  = '0;
        dec_if.ready        = 1'b0;
        nest_depth          = 0;
        doc_faulted         = 1'b0;
        name_len_held       = '0;
        name_len_limit      = MAX_NAME_LEN_RESET;
        tags_queued         = 0;
        tags_taken          = 0;
        error_count         = 0;
        noise_permille      = 0;
        set_idling(0);
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, with the reset name limit in force.
        put(CMD_CLOSE, 5'd31, 12'd4095);                 // close with nothing open
        put(CMD_CHARS, 5'd0, 12'd0);                     // sticky fault
        put(CMD_START, 5'd31, 12'd4095);
        put(CMD_CHARS, 5'd16, 12'd4095);                 // text outside any element
        put(CMD_START, 5'd0, 12'd0);
        put(CMD_OPEN, 5'd31, 12'd0);                     // unknown element
        put(CMD_START, 5'd0, 12'd0);
        put(CMD_OPEN, K_PARAM, 12'd0);                   // wrong parent
        put(CMD_START, 5'd0, 12'd0);
        put(CMD_OPEN, K_METHODRESPONSE, 12'd0);
        put(CMD_OPEN, K_PARAMS, 12'd0);
        put(CMD_OPEN, K_PARAM, 12'd0);
        put(CMD_OPEN, K_VALUE, 12'd0);
        put(CMD_OPEN, K_ARRAY, 12'd0);
        put(CMD_OPEN, K_DATA, 12'd0);
        put(CMD_OPEN, K_VALUE, 12'd0);
        put(CMD_OPEN, K_I4, 12'd0);
        put(CMD_CLOSE, 5'd0, 12'd0);                     // scalar closed without text
        put(CMD_CLOSE, 5'd0, 12'd0);
        put(CMD_CHARS, 5'd0, 12'd7);                     // text inside data
        put(CMD_START, 5'd0, 12'd0);
        put(CMD_OPEN, K_METHODRESPONSE, 12'd0);
        put(CMD_OPEN, K_PARAMS, 12'd0);
        put(CMD_OPEN, K_PARAM, 12'd0);
        put(CMD_OPEN, K_VALUE, 12'd0);
        put(CMD_OPEN, K_STRUCT, 12'd0);
        put(CMD_OPEN, K_MEMBER, 12'd0);
        put(CMD_OPEN, K_NAME, 12'd0);
        put(CMD_CHARS, 5'd0, MAX_NAME_LEN_RESET);        // longest name allowed
        put(CMD_CLOSE, 5'd0, 12'd0);
        put(CMD_OPEN, K_NAME, 12'd0);
        put(CMD_CHARS, 5'd0, MAX_NAME_LEN_RESET + 12'd1); // one character too long
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       set_name_limit(12'd1);
                1:       set_name_limit(12'd4095);
                2:       set_name_limit(LEN_W'($urandom_range(4094, 2)));
                3:       set_name_limit(MAX_NAME_LEN_RESET);
                default: set_name_limit(LEN_W'($urandom_range(40, 1)));
            endcase
            set_idling(modes[p]);
            phase_end = tags_queued + 385;
            while (tags_queued < phase_end) gen_document();
            wait_drained();
        end

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== xmlrpc_element_nesting_checker_core.f =====
+incdir+design
design/xnc_pkg.sv
design/xnc_in_if.sv
design/xnc_out_if.sv
design/xnc_stack.sv
design/xmlrpc_element_nesting_checker_core.sv
sim/xmlrpc_element_nesting_checker_core_tb.sv
